### src/gjk_pkg.sv
// Shared constants, types and vector helpers of the GJK simplex step block.
package gjk_pkg;

    localparam int COORD_W     = 16;
    localparam int DIR_W       = 51;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int MUL_A_W     = 2 * DIFF_W + 2;
    localparam int MUL_B_W     = DIFF_W + 1;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int LO_W        = 32;
    localparam int ACC_W       = DIR_W + MUL_B_W + 3;
    localparam int CNT_W       = 3;
    localparam int STEP_W      = 3;
    localparam int N_STEPS     = 6;
    localparam int IN_W        = 3 * COORD_W;
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W       = 3 * DIR_W + CNT_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    typedef logic [2:0][COORD_W-1:0] pvec_t;
    typedef logic [2:0][DIR_W-1:0]   dvec_t;
    typedef logic [CNT_W-1:0]        cnt_t;
    typedef logic [STEP_W-1:0]       step_t;

    typedef enum logic [1:0] {
        ST_CONT        = 2'd0,
        ST_SEPARATED   = 2'd1,
        ST_INTERSECT   = 2'd2,
        ST_NOT_STARTED = 2'd3
    } status_t;

    typedef enum logic {
        VOP_CROSS = 1'b0,
        VOP_DOT   = 1'b1
    } vop_t;

    typedef struct packed {
        logic start;
        vop_t op;
        logic neg;
    } vreq_t;

    typedef struct packed {
        logic done;
        logic flag;
    } vrsp_t;

    typedef enum logic [4:0] {
        S_IDLE, S_TEST, S_PREP,
        S_L_DOT, S_L_X1, S_L_X2,
        S_T_ABC, S_T_X1, S_T_D1, S_T_D2, S_T_X2, S_T_D3, S_T_D4,
        S_Q_X1, S_Q_D1, S_Q_X2, S_Q_D2, S_Q_X3, S_Q_D3,
        S_OUT
    } state_t;

    function automatic dvec_t sext_pt(pvec_t p);
        dvec_t r;
        for (int i = 0; i < 3; i++) begin
            r[i] = {{(DIR_W-COORD_W){p[i][COORD_W-1]}}, p[i]};
        end
        return r;
    endfunction

    function automatic dvec_t dneg(dvec_t a);
        dvec_t r;
        for (int i = 0; i < 3; i++) begin
            r[i] = ~a[i] + 1'b1;
        end
        return r;
    endfunction

    function automatic dvec_t dsub(dvec_t a, dvec_t b);
        dvec_t r;
        for (int i = 0; i < 3; i++) begin
            r[i] = a[i] - b[i];
        end
        return r;
    endfunction

endpackage

### src/gjk_vec_unit.sv
// Shared multiply-accumulate unit: wrapped cross products and exact dot product sign tests.
module gjk_vec_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  gjk_pkg::vreq_t req,
    input  gjk_pkg::dvec_t u,
    input  gjk_pkg::dvec_t v,
    output gjk_pkg::vrsp_t rsp,
    output gjk_pkg::dvec_t res
);

    logic                 issuing_reg;
    gjk_pkg::step_t       k_reg;
    logic                 pv_reg;
    gjk_pkg::step_t       pk_reg;
    logic                 psub_reg;
    logic                 pshift_reg;
    logic                 done_reg;
    logic                 flag_reg;
    gjk_pkg::vop_t        op_reg;
    logic                 neg_reg;
    gjk_pkg::dvec_t       u_reg;
    gjk_pkg::dvec_t       v_reg;
    gjk_pkg::dvec_t       res_reg;
    logic signed [gjk_pkg::PROD_W-1:0] prod_reg;
    logic signed [gjk_pkg::ACC_W-1:0]  acc_reg;

    logic [1:0]                         ua;
    logic [1:0]                         vb;
    logic [1:0]                         comp;
    logic                               half;
    logic [gjk_pkg::MUL_A_W-1:0]        a_op;
    logic [gjk_pkg::MUL_B_W-1:0]        b_op;
    logic                               sub_c;
    logic                               shift_c;
    logic signed [gjk_pkg::PROD_W-1:0]  prod_next;
    logic signed [gjk_pkg::ACC_W-1:0]   prod_ext;
    logic signed [gjk_pkg::ACC_W-1:0]   term;
    logic signed [gjk_pkg::ACC_W-1:0]   acc_sum;
    logic [gjk_pkg::DIR_W-1:0]          dsum;
    logic                               last_p;

    // Cross product terms are issued x, y, z with the positive term first.
    always_comb
    begin
        ua = 2'd0;
        vb = 2'd0;
        unique case (k_reg)
            3'd0: begin ua = 2'd1; vb = 2'd2; end
            3'd1: begin ua = 2'd2; vb = 2'd1; end
            3'd2: begin ua = 2'd2; vb = 2'd0; end
            3'd3: begin ua = 2'd0; vb = 2'd2; end
            3'd4: begin ua = 2'd0; vb = 2'd1; end
            3'd5: begin ua = 2'd1; vb = 2'd0; end
            default: begin ua = 2'd0; vb = 2'd0; end
        endcase
        comp = k_reg[2:1];
        half = k_reg[0];
        if (op_reg == gjk_pkg::VOP_CROSS)
        begin
            a_op    = u_reg[ua][gjk_pkg::MUL_A_W-1:0];
            b_op    = v_reg[vb][gjk_pkg::MUL_B_W-1:0];
            sub_c   = half;
            shift_c = 1'b0;
        end
        else
        begin
            // The dot product splits the wide operand into an unsigned low word
            // and a signed high word so that each product stays narrow.
            if (half)
            begin
                a_op = {{(gjk_pkg::MUL_A_W-(gjk_pkg::DIR_W-gjk_pkg::LO_W))
                         {u_reg[comp][gjk_pkg::DIR_W-1]}},
                        u_reg[comp][gjk_pkg::DIR_W-1:gjk_pkg::LO_W]};
            end
            else
            begin
                a_op = {{(gjk_pkg::MUL_A_W-gjk_pkg::LO_W){1'b0}},
                        u_reg[comp][gjk_pkg::LO_W-1:0]};
            end
            b_op    = v_reg[comp][gjk_pkg::MUL_B_W-1:0];
            sub_c   = 1'b0;
            shift_c = half;
        end
    end

    assign prod_next = $signed(a_op) * $signed(b_op);
    assign prod_ext  = {{(gjk_pkg::ACC_W-gjk_pkg::PROD_W){prod_reg[gjk_pkg::PROD_W-1]}},
                        prod_reg};
    assign term      = pshift_reg ? (prod_ext <<< gjk_pkg::LO_W) : prod_ext;
    assign acc_sum   = psub_reg ? (acc_reg - term) : (acc_reg + term);
    assign dsum      = acc_sum[gjk_pkg::DIR_W-1:0];
    assign last_p    = (pk_reg == gjk_pkg::step_t'(gjk_pkg::N_STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issuing_reg <= 1'b0;
            k_reg       <= '0;
            pv_reg      <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            pv_reg   <= issuing_reg;
            done_reg <= pv_reg && last_p;
            if (req.start)
            begin
                issuing_reg <= 1'b1;
                k_reg       <= '0;
            end
            else if (issuing_reg)
            begin
                k_reg <= k_reg + 1'b1;
                if (k_reg == gjk_pkg::step_t'(gjk_pkg::N_STEPS - 1))
                begin
                    issuing_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        pk_reg     <= k_reg;
        psub_reg   <= sub_c;
        pshift_reg <= shift_c;
        if (req.start)
        begin
            op_reg  <= req.op;
            neg_reg <= req.neg;
            u_reg   <= u;
            v_reg   <= v;
            acc_reg <= '0;
        end
        else if (pv_reg)
        begin
            if (op_reg == gjk_pkg::VOP_CROSS && psub_reg)
            begin
                acc_reg <= '0;
                res_reg[pk_reg[2:1]] <= neg_reg ? (~dsum + 1'b1) : dsum;
            end
            else
            begin
                acc_reg <= acc_sum;
            end
            if (last_p)
            begin
                flag_reg <= (acc_sum > 0);
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.flag = flag_reg;
    assign res      = res_reg;

endmodule

### src/gjk_simplex_step.sv
// GJK simplex refinement step: top level with sequencer, simplex storage and output register.
// A request is taken only while the sequencer is idle; its result is loaded into the output
// register once that register is free, and only then is a new request taken.
// Each cross product or dot test occupies the one shared 36x18 multiplier;
// a start, an inactive point or a separation needs at most one such operation.
// A new request is taken while the previous result still waits in the output register.
// Reset clears the sequencer, the vertex count, the query flag and the output valid.
module gjk_simplex_step (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [gjk_pkg::IN_TDATA_W-1:0]     s_tdata,   // support_x, support_y, support_z
    input  logic [0:0]                         s_tuser,   // start_req
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [gjk_pkg::OUT_TDATA_W-1:0]    m_tdata,   // next_dir_x, _y, _z, simplex_size
    output logic [1:0]                         m_tuser    // status
);

    gjk_pkg::state_t  state_reg, state_next;
    logic             issued_reg, issued_next;
    gjk_pkg::cnt_t    cnt_reg, cnt_next;
    logic             active_reg, active_next;
    logic             out_valid_reg, out_valid_next;
    gjk_pkg::pvec_t   pts_reg [4];
    gjk_pkg::pvec_t   pts_next [4];
    gjk_pkg::pvec_t   p_reg, p_next;
    gjk_pkg::dvec_t   dir_reg, dir_next;
    gjk_pkg::dvec_t   abc_reg, abc_next;
    gjk_pkg::dvec_t   ab_reg, ab_next;
    gjk_pkg::dvec_t   ac_reg, ac_next;
    gjk_pkg::dvec_t   ad_reg, ad_next;
    gjk_pkg::dvec_t   ao_reg, ao_next;
    gjk_pkg::status_t rstat_reg, rstat_next;
    logic [gjk_pkg::OUT_W-1:0] out_reg, out_next;
    gjk_pkg::status_t ostat_reg, ostat_next;

    gjk_pkg::vreq_t   vu_req;
    gjk_pkg::vrsp_t   vu_rsp;
    gjk_pkg::dvec_t   vu_u, vu_v, vu_res;
    logic             use_vu;
    logic             done;
    logic             flag;
    logic             out_load;
    gjk_pkg::pvec_t   pin;
    gjk_pkg::cnt_t    osize;
    gjk_pkg::dvec_t   odir;

    assign done     = vu_rsp.done;
    assign flag     = vu_rsp.flag;
    assign pin      = s_tdata[gjk_pkg::IN_W-1:0];
    assign out_load = (state_reg == gjk_pkg::S_OUT) && (!out_valid_reg || m_tready);

    gjk_vec_unit u_vec (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (vu_req),
        .u     (vu_u),
        .v     (vu_v),
        .rsp   (vu_rsp),
        .res   (vu_res)
    );

    // Operand selection for the shared unit.
    always_comb
    begin
        use_vu = 1'b1;
        vu_u   = ab_reg;
        vu_v   = ao_reg;
        vu_req.op  = gjk_pkg::VOP_CROSS;
        vu_req.neg = 1'b0;
        unique case (state_reg)
            gjk_pkg::S_TEST:  begin vu_u = dir_reg; vu_v = gjk_pkg::sext_pt(p_reg);
                                    vu_req.op = gjk_pkg::VOP_DOT; end
            gjk_pkg::S_L_DOT: begin vu_u = ab_reg;  vu_v = ao_reg; vu_req.op = gjk_pkg::VOP_DOT; end
            gjk_pkg::S_L_X1:  begin vu_u = ab_reg;  vu_v = ao_reg; end
            gjk_pkg::S_L_X2:  begin vu_u = vu_res;  vu_v = ab_reg; end
            gjk_pkg::S_T_ABC: begin vu_u = ab_reg;  vu_v = ac_reg; end
            gjk_pkg::S_T_X1:  begin vu_u = abc_reg; vu_v = ac_reg; end
            gjk_pkg::S_T_D1:  begin vu_u = vu_res;  vu_v = ao_reg; vu_req.op = gjk_pkg::VOP_DOT; end
            gjk_pkg::S_T_D2:  begin vu_u = ac_reg;  vu_v = ao_reg; vu_req.op = gjk_pkg::VOP_DOT; end
            // ab x abc is taken as -(abc x ab) so the narrow operand sits on the short port.
            gjk_pkg::S_T_X2:  begin vu_u = abc_reg; vu_v = ab_reg; vu_req.neg = 1'b1; end
            gjk_pkg::S_T_D3:  begin vu_u = vu_res;  vu_v = ao_reg; vu_req.op = gjk_pkg::VOP_DOT; end
            gjk_pkg::S_T_D4:  begin vu_u = abc_reg; vu_v = ao_reg; vu_req.op = gjk_pkg::VOP_DOT; end
            gjk_pkg::S_Q_X1:  begin vu_u = ab_reg;  vu_v = ac_reg; end
            gjk_pkg::S_Q_D1:  begin vu_u = vu_res;  vu_v = ao_reg; vu_req.op = gjk_pkg::VOP_DOT; end
            gjk_pkg::S_Q_X2:  begin vu_u = ac_reg;  vu_v = ad_reg; end
            gjk_pkg::S_Q_D2:  begin vu_u = vu_res;  vu_v = ao_reg; vu_req.op = gjk_pkg::VOP_DOT; end
            gjk_pkg::S_Q_X3:  begin vu_u = ad_reg;  vu_v = ab_reg; end
            gjk_pkg::S_Q_D3:  begin vu_u = vu_res;  vu_v = ao_reg; vu_req.op = gjk_pkg::VOP_DOT; end
            default:          use_vu = 1'b0;
        endcase
        vu_req.start = use_vu && !issued_reg;
        issued_next  = use_vu && !done;
        s_tready     = (state_reg == gjk_pkg::S_IDLE);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gjk_pkg::S_IDLE:
                if (s_tvalid)
                begin
                    state_next = (s_tuser[0] || !active_reg) ? gjk_pkg::S_OUT : gjk_pkg::S_TEST;
                end
            gjk_pkg::S_TEST:  if (done) state_next = flag ? gjk_pkg::S_PREP : gjk_pkg::S_OUT;
            gjk_pkg::S_PREP:
                if (cnt_reg == gjk_pkg::cnt_t'(2))
                    state_next = gjk_pkg::S_L_DOT;
                else if (cnt_reg == gjk_pkg::cnt_t'(3))
                    state_next = gjk_pkg::S_T_ABC;
                else
                    state_next = gjk_pkg::S_Q_X1;
            gjk_pkg::S_L_DOT: if (done) state_next = flag ? gjk_pkg::S_L_X1 : gjk_pkg::S_OUT;
            gjk_pkg::S_L_X1:  if (done) state_next = gjk_pkg::S_L_X2;
            gjk_pkg::S_L_X2:  if (done) state_next = gjk_pkg::S_OUT;
            gjk_pkg::S_T_ABC: if (done) state_next = gjk_pkg::S_T_X1;
            gjk_pkg::S_T_X1:  if (done) state_next = gjk_pkg::S_T_D1;
            gjk_pkg::S_T_D1:  if (done) state_next = flag ? gjk_pkg::S_T_D2 : gjk_pkg::S_T_X2;
            gjk_pkg::S_T_D2:  if (done) state_next = flag ? gjk_pkg::S_PREP : gjk_pkg::S_L_DOT;
            gjk_pkg::S_T_X2:  if (done) state_next = gjk_pkg::S_T_D3;
            gjk_pkg::S_T_D3:  if (done) state_next = flag ? gjk_pkg::S_L_DOT : gjk_pkg::S_T_D4;
            gjk_pkg::S_T_D4:  if (done) state_next = gjk_pkg::S_OUT;
            gjk_pkg::S_Q_X1:  if (done) state_next = gjk_pkg::S_Q_D1;
            gjk_pkg::S_Q_D1:  if (done) state_next = flag ? gjk_pkg::S_PREP : gjk_pkg::S_Q_X2;
            gjk_pkg::S_Q_X2:  if (done) state_next = gjk_pkg::S_Q_D2;
            gjk_pkg::S_Q_D2:  if (done) state_next = flag ? gjk_pkg::S_PREP : gjk_pkg::S_Q_X3;
            gjk_pkg::S_Q_X3:  if (done) state_next = gjk_pkg::S_Q_D3;
            gjk_pkg::S_Q_D3:  if (done) state_next = flag ? gjk_pkg::S_PREP : gjk_pkg::S_OUT;
            gjk_pkg::S_OUT:   if (out_load) state_next = gjk_pkg::S_IDLE;
            default:          state_next = gjk_pkg::S_IDLE;
        endcase
    end

    // Simplex, direction and result updates.
    always_comb
    begin
        cnt_next    = cnt_reg;
        active_next = active_reg;
        for (int i = 0; i < 4; i++) pts_next[i] = pts_reg[i];
        p_next      = p_reg;
        dir_next    = dir_reg;
        abc_next    = abc_reg;
        ab_next     = ab_reg;
        ac_next     = ac_reg;
        ad_next     = ad_reg;
        ao_next     = ao_reg;
        rstat_next  = rstat_reg;
        unique case (state_reg)
            gjk_pkg::S_IDLE:
                if (s_tvalid)
                begin
                    p_next     = pin;
                    rstat_next = gjk_pkg::ST_CONT;
                    if (s_tuser[0])
                    begin
                        pts_next[0] = pin;
                        cnt_next    = gjk_pkg::cnt_t'(1);
                        dir_next    = gjk_pkg::dneg(gjk_pkg::sext_pt(pin));
                        active_next = 1'b1;
                    end
                    else if (!active_reg)
                    begin
                        rstat_next = gjk_pkg::ST_NOT_STARTED;
                    end
                end
            gjk_pkg::S_TEST:
                if (done)
                begin
                    if (flag)
                    begin
                        pts_next[3] = pts_reg[2];
                        pts_next[2] = pts_reg[1];
                        pts_next[1] = pts_reg[0];
                        pts_next[0] = p_reg;
                        cnt_next = ((cnt_reg > gjk_pkg::cnt_t'(3)) ? gjk_pkg::cnt_t'(3) : cnt_reg)
                                   + gjk_pkg::cnt_t'(1);
                    end
                    else
                    begin
                        rstat_next  = gjk_pkg::ST_SEPARATED;
                        active_next = 1'b0;
                    end
                end
            gjk_pkg::S_PREP:
            begin
                ab_next = gjk_pkg::dsub(gjk_pkg::sext_pt(pts_reg[1]), gjk_pkg::sext_pt(pts_reg[0]));
                ac_next = gjk_pkg::dsub(gjk_pkg::sext_pt(pts_reg[2]), gjk_pkg::sext_pt(pts_reg[0]));
                ad_next = gjk_pkg::dsub(gjk_pkg::sext_pt(pts_reg[3]), gjk_pkg::sext_pt(pts_reg[0]));
                ao_next = gjk_pkg::dneg(gjk_pkg::sext_pt(pts_reg[0]));
            end
            gjk_pkg::S_L_DOT:
                if (done && !flag)
                begin
                    dir_next = ao_reg;
                    cnt_next = gjk_pkg::cnt_t'(1);
                end
            gjk_pkg::S_L_X2:
                if (done)
                begin
                    dir_next = vu_res;
                    cnt_next = gjk_pkg::cnt_t'(2);
                end
            gjk_pkg::S_T_ABC: if (done) abc_next = vu_res;
            gjk_pkg::S_T_D2:
                if (done)
                begin
                    // Keeping a and c reruns the line case, whose edge test is known to pass.
                    cnt_next = gjk_pkg::cnt_t'(2);
                    if (flag) pts_next[1] = pts_reg[2];
                end
            gjk_pkg::S_T_D3: if (done && flag) cnt_next = gjk_pkg::cnt_t'(2);
            gjk_pkg::S_T_D4:
                if (done)
                begin
                    cnt_next = gjk_pkg::cnt_t'(3);
                    if (flag)
                    begin
                        dir_next = abc_reg;
                    end
                    else
                    begin
                        dir_next    = gjk_pkg::dneg(abc_reg);
                        pts_next[1] = pts_reg[2];
                        pts_next[2] = pts_reg[1];
                    end
                end
            gjk_pkg::S_Q_D1: if (done && flag) cnt_next = gjk_pkg::cnt_t'(3);
            gjk_pkg::S_Q_D2:
                if (done && flag)
                begin
                    pts_next[1] = pts_reg[2];
                    pts_next[2] = pts_reg[3];
                    cnt_next    = gjk_pkg::cnt_t'(3);
                end
            gjk_pkg::S_Q_D3:
                if (done)
                begin
                    if (flag)
                    begin
                        pts_next[1] = pts_reg[3];
                        pts_next[2] = pts_reg[1];
                        cnt_next    = gjk_pkg::cnt_t'(3);
                    end
                    else
                    begin
                        rstat_next  = gjk_pkg::ST_INTERSECT;
                        active_next = 1'b0;
                        cnt_next    = gjk_pkg::cnt_t'(4);
                    end
                end
            default: ;
        endcase
    end

    // Output register.
    always_comb
    begin
        osize = (rstat_reg == gjk_pkg::ST_NOT_STARTED) ? gjk_pkg::cnt_t'(0) : cnt_reg;
        odir  = (rstat_reg == gjk_pkg::ST_CONT) ? dir_reg : '0;
        out_next   = out_load ? {osize, odir[2], odir[1], odir[0]} : out_reg;
        ostat_next = out_load ? rstat_reg : ostat_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gjk_pkg::S_IDLE;
            issued_reg    <= 1'b0;
            cnt_reg       <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issued_reg    <= issued_next;
            cnt_reg       <= cnt_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++) pts_reg[i] <= pts_next[i];
        p_reg     <= p_next;
        dir_reg   <= dir_next;
        abc_reg   <= abc_next;
        ab_reg    <= ab_next;
        ac_reg    <= ac_next;
        ad_reg    <= ad_next;
        ao_reg    <= ao_next;
        rstat_reg <= rstat_next;
        out_reg   <= out_next;
        ostat_reg <= ostat_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = gjk_pkg::OUT_TDATA_W'(out_reg);
    assign m_tuser  = ostat_reg;

    a_active_count: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (cnt_reg >= gjk_pkg::cnt_t'(1) && cnt_reg <= gjk_pkg::cnt_t'(4)))
        else $error("active query with impossible vertex count");

    a_single_issue: assert property (@(posedge clk) disable iff (!rst_n)
        vu_req.start |=> !vu_req.start)
        else $error("shared unit started twice in a row");

    a_intersect_size: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == gjk_pkg::ST_INTERSECT) |->
        (out_reg[3*gjk_pkg::DIR_W +: gjk_pkg::CNT_W] == gjk_pkg::cnt_t'(4)))
        else $error("intersecting result without a full simplex");

    a_cont_size: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == gjk_pkg::ST_CONT) |->
        (out_reg[3*gjk_pkg::DIR_W +: gjk_pkg::CNT_W] != gjk_pkg::cnt_t'(0)))
        else $error("continuing result with an empty simplex");

endmodule

### dv/tb_gjk_simplex_step.sv
// Self-checking testbench for the GJK simplex refinement step block.
module tb_gjk_simplex_step;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [127:0] wide_t;
    typedef struct { wide_t x, y, z; } v3_t;
    typedef struct {
        gjk_pkg::status_t st;
        logic [50:0]      dx, dy, dz;
        logic [2:0]       size;
    } step_res_t;

    // Scoreboard: predicts each step of the simplex search and checks results in order.
    class simplex_scoreboard;
        v3_t         pts[4];
        int unsigned npts;
        v3_t         dir;
        bit          active;
        step_res_t   pending_q[$];
        int          errors;

        function new();
            v3_t zero;
            zero = '{0, 0, 0};
            for (int i = 0; i < 4; i++) pts[i] = zero;
            npts = 0;
            dir = zero;
            active = 0;
            errors = 0;
        endfunction

        static function wide_t wrap51(wide_t v);
            logic [50:0] t;
            t = v[50:0];
            return {{77{t[50]}}, t};
        endfunction

        static function v3_t vsub(v3_t a, v3_t b);
            v3_t r;
            r = '{a.x - b.x, a.y - b.y, a.z - b.z};
            return r;
        endfunction

        static function v3_t vneg(v3_t a);
            v3_t r;
            r = '{-a.x, -a.y, -a.z};
            return r;
        endfunction

        static function v3_t vcross(v3_t a, v3_t b);
            v3_t r;
            r.x = wrap51(a.y * b.z - a.z * b.y);
            r.y = wrap51(a.z * b.x - a.x * b.z);
            r.z = wrap51(a.x * b.y - a.y * b.x);
            return r;
        endfunction

        // The dot product fits easily in 128 bits, so the test is exact.
        static function bit towards(v3_t a, v3_t b);
            wide_t s;
            s = a.x * b.x + a.y * b.y + a.z * b.z;
            return s > 0;
        endfunction

        function void line_case();
            v3_t ab, ao;
            ab = vsub(pts[1], pts[0]);
            ao = vneg(pts[0]);
            if (towards(ab, ao)) begin
                dir = vcross(vcross(ab, ao), ab);
                npts = 2;
            end else begin
                dir = ao;
                npts = 1;
            end
        endfunction

        function void triangle_case();
            v3_t a, b, c, ab, ac, ao, abc;
            a = pts[0]; b = pts[1]; c = pts[2];
            ab = vsub(b, a);
            ac = vsub(c, a);
            ao = vneg(a);
            abc = vcross(ab, ac);
            if (towards(vcross(abc, ac), ao)) begin
                if (towards(ac, ao)) begin
                    pts[1] = c;
                    npts = 2;
                    dir = vcross(vcross(ac, ao), ac);
                end else begin
                    npts = 2;
                    line_case();
                end
            end else if (towards(vcross(ab, abc), ao)) begin
                npts = 2;
                line_case();
            end else if (towards(abc, ao)) begin
                npts = 3;
                dir = abc;
            end else begin
                pts[1] = c;
                pts[2] = b;
                npts = 3;
                dir = vneg(abc);
            end
        endfunction

        // Returns 1 when the tetrahedron encloses the origin.
        function bit tetra_case();
            v3_t a, b, c, d, ab, ac, ad, ao;
            a = pts[0]; b = pts[1]; c = pts[2]; d = pts[3];
            ab = vsub(b, a);
            ac = vsub(c, a);
            ad = vsub(d, a);
            ao = vneg(a);
            if (towards(vcross(ab, ac), ao)) begin
                npts = 3;
                triangle_case();
                return 0;
            end
            if (towards(vcross(ac, ad), ao)) begin
                pts[1] = c;
                pts[2] = d;
                npts = 3;
                triangle_case();
                return 0;
            end
            if (towards(vcross(ad, ab), ao)) begin
                pts[1] = d;
                pts[2] = b;
                npts = 3;
                triangle_case();
                return 0;
            end
            npts = 4;
            return 1;
        endfunction

        function void note_request(bit start, v3_t p);
            step_res_t r;
            v3_t od;
            int unsigned n;
            od = '{0, 0, 0};
            if (start) begin
                pts[0] = p;
                npts = 1;
                dir = vneg(p);
                active = 1;
                r.st = gjk_pkg::ST_CONT;
                r.size = 1;
                od = dir;
            end else if (!active) begin
                r.st = gjk_pkg::ST_NOT_STARTED;
                r.size = 0;
            end else if (!towards(dir, p)) begin
                r.st = gjk_pkg::ST_SEPARATED;
                r.size = npts[2:0];
                active = 0;
            end else begin
                n = (npts > 3) ? 3 : npts;
                for (int i = 3; i > 0; i--) begin
                    if (i <= n) pts[i] = pts[i-1];
                end
                pts[0] = p;
                npts = n + 1;
                r.st = gjk_pkg::ST_CONT;
                if (npts == 2) begin
                    line_case();
                end else if (npts == 3) begin
                    triangle_case();
                end else if (tetra_case()) begin
                    r.st = gjk_pkg::ST_INTERSECT;
                    active = 0;
                end
                r.size = npts[2:0];
                if (r.st == gjk_pkg::ST_CONT) od = dir;
            end
            r.dx = od.x[50:0];
            r.dy = od.y[50:0];
            r.dz = od.z[50:0];
            pending_q = {pending_q, r};
        endfunction

        function void check_result(logic [gjk_pkg::OUT_TDATA_W-1:0] d, logic [1:0] u);
            step_res_t e;
            if (pending_q.size() == 0) begin
                $error("result with no request outstanding: status %0d", u);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (u !== e.st) begin
                $error("status: expected %0d, got %0d", e.st, u);
                errors++;
            end
            if (d[50:0] !== e.dx) begin
                $error("next_dir_x: expected %h, got %h", e.dx, d[50:0]);
                errors++;
            end
            if (d[101:51] !== e.dy) begin
                $error("next_dir_y: expected %h, got %h", e.dy, d[101:51]);
                errors++;
            end
            if (d[152:102] !== e.dz) begin
                $error("next_dir_z: expected %h, got %h", e.dz, d[152:102]);
                errors++;
            end
            if (d[155:153] !== e.size) begin
                $error("simplex_size: expected %0d, got %0d", e.size, d[155:153]);
                errors++;
            end
        endfunction
    endclass

    logic                              clk;
    logic                              rst_n;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [gjk_pkg::IN_TDATA_W-1:0]    s_tdata;
    logic [0:0]                        s_tuser;
    logic                              m_tvalid;
    logic                              m_tready;
    logic [gjk_pkg::OUT_TDATA_W-1:0]   m_tdata;
    logic [1:0]                        m_tuser;

    simplex_scoreboard sb = new();
    bit calm;
    bit hold_rx;
    int stall_cycles;

    gjk_simplex_step i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    end

    // Watchdog on cycles with no request and no result moving.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= 20000) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_rx) begin
                m_tready <= 1'b0;
                repeat (300) @(negedge clk);
                hold_rx = 0;
            end else begin
                m_tready <= calm || ($urandom_range(0, 99) >= 23);
            end
        end
    end

    task automatic send_point(bit start, logic signed [15:0] x, logic signed [15:0] y,
                              logic signed [15:0] z);
        v3_t p;
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < 23) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= start;
        s_tdata  <= {z, y, x};
        do @(posedge clk); while (!s_tready);
        p = '{wide_t'(x), wide_t'(y), wide_t'(z)};
        sb.note_request(start, p);
    endtask

    function automatic logic signed [15:0] rand_coord(int span);
        if (span == 0) return 16'($urandom);
        return 16'($urandom_range(0, 2 * span) - span);
    endfunction

    // Mostly well-formed queries: points are flipped toward the current search direction.
    task automatic random_point();
        logic signed [15:0] x, y, z;
        int span;
        bit start;
        v3_t p;
        case ($urandom_range(0, 9))
            0, 1:    span = 0;
            2, 3, 4: span = 6;
            5, 6:    span = 40;
            default: span = 2000;
        endcase
        x = rand_coord(span);
        y = rand_coord(span);
        z = rand_coord(span);
        start = sb.active ? ($urandom_range(0, 99) < 3) : ($urandom_range(0, 99) < 85);
        if (!start && sb.active && span != 0 && $urandom_range(0, 99) < 88) begin
            p = '{wide_t'(x), wide_t'(y), wide_t'(z)};
            if (!simplex_scoreboard::towards(sb.dir, p)) begin
                x = -x;
                y = -y;
                z = -z;
            end
        end
        send_point(start, x, y, z);
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = '0;
        s_tdata  = '0;
        calm     = 0;
        hold_rx  = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: no query yet, extremes, zero dot product, restart while active.
        send_point(0, 16'sh7fff, -16'sh8000, 16'sh0001);
        send_point(1, 16'sh7fff, -16'sh8000, 16'sh0000);
        send_point(0, -16'sh8000, 16'sh7fff, -16'sh8000);
        send_point(0, -16'sh8000, 16'sh7fff, 16'sh7fff);
        send_point(1, -16'sh8000, -16'sh8000, -16'sh8000);
        send_point(0, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_point(1, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_point(1, 16'sd0, 16'sd0, 16'sd0);
        send_point(0, 16'sd5, 16'sd5, 16'sd5);
        send_point(1, 16'sd10, 16'sd0, 16'sd0);
        send_point(0, 16'sd0, 16'sd10, 16'sd0);
        send_point(0, -16'sd1, 16'sd0, 16'sd0);
        send_point(1, 16'sd3, 16'sd1, 16'sd1);
        send_point(0, -16'sd3, 16'sd1, 16'sd1);
        send_point(0, 16'sd0, -16'sd3, 16'sd1);
        send_point(0, 16'sd0, 16'sd0, -16'sd3);
        send_point(0, 16'sd0, 16'sd3, 16'sd3);
        send_point(1, 16'sd1, 16'sd0, 16'sd0);
        send_point(0, 16'sd1, 16'sd0, 16'sd0);
        send_point(0, 16'sd9, 16'sd9, 16'sd9);

        for (int n = 0; n < 1500; n++) begin
            calm = (n >= 200 && n < 400);
            if (n == 600) hold_rx = 1;
            if (n == 900) begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                while (sb.pending_q.size() != 0) @(negedge clk);
            end
            random_point();
        end
        calm = 0;
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
